[sv/rgil_pkg.sv]
// ----------------------------------------------------------------------------
// rgil_pkg
// Shared types and constants for the ray / pixel-grid chord length block.
// ----------------------------------------------------------------------------
package rgil_pkg;

    localparam int MAX_HEIGHT = 16;
    localparam int MAX_WIDTH  = 16;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd0;
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd1;
    localparam logic [1:0] REG_GRID_SIZE   = 2'd2;

    // Fraction bits of the chord length before scaling, and the number of root bits.
    localparam int LEN_FRAC  = 20;
    localparam int ROOT_BITS = 21;
    localparam int ACC_W     = 68;

    typedef logic [4:0] dim_t;
    typedef logic [8:0] pt_t;

    // One segment handed from the tracer to the length unit.
    typedef struct packed {
        pt_t        dn;
        pt_t        dd;
        pt_t        l2;
        logic [7:0] ray;
        logic [3:0] px;
        logic [3:0] py;
        logic [7:0] pidx;
        logic       last;
    } seg_t;

    typedef enum logic {
        F_IDLE,
        F_RUN
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PREP,
        B_PROD,
        B_ITER,
        B_SCALE,
        B_OUT
    } back_state_t;

endpackage

[sv/ray_grid_intersection_lengths_top.sv]
// ----------------------------------------------------------------------------
// ray_grid_intersection_lengths_top
// The tracer emits one segment per cycle into a 4-entry queue while the
// queue is not full; the length unit finishes each segment (21 root steps)
// before it pops the next; a new ray is taken once the tracer is done.
// Reset clears all control state and loads height 16, width 16, size 256.
// ----------------------------------------------------------------------------
module ray_grid_intersection_lengths_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // tx_row[3:0], rx_row[7:4]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // ray_index[7:0], pixel_x[11:8], pixel_y[15:12],
                                    // pixel_index[23:16], seg_length[48:24]
    output logic        m_tlast
);
    import rgil_pkg::*;

    logic [4:0]  height_reg, width_reg;
    logic [15:0] size_reg;

    logic        push, pop, full, empty;
    seg_t        push_data, pop_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= 5'd16;
            width_reg  <= 5'd16;
            size_reg   <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_GRID_HEIGHT: height_reg <= cfg_data[4:0];
                REG_GRID_WIDTH:  width_reg  <= cfg_data[4:0];
                REG_GRID_SIZE:   size_reg   <= cfg_data;
                default:         size_reg   <= size_reg;
            endcase
        end
    end

    rgil_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .grid_height (height_reg),
        .grid_width  (width_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .push        (push),
        .push_data   (push_data),
        .full        (full)
    );

    rgil_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    rgil_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .grid_size (size_reg),
        .empty     (empty),
        .pop       (pop),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[sv/rgil_front.sv]
// ----------------------------------------------------------------------------
// rgil_front
// Accepts a ray, then walks the merged vertical and horizontal crossings
// and pushes one segment per cycle into the queue while it is not full.
// ----------------------------------------------------------------------------
module rgil_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [4:0]          grid_height,
    input  logic [4:0]          grid_width,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // tx_row[3:0], rx_row[7:4]
    output logic                push,
    output rgil_pkg::seg_t      push_data,
    input  logic                full
);
    import rgil_pkg::*;

    front_state_t state_reg, state_next;

    dim_t       h_eff, w_eff;
    logic [3:0] tx_c, rx_c;
    logic [3:0] m_c;
    logic       neg_c, flat_c;

    dim_t       w_reg;
    logic [3:0] m_reg;
    logic       neg_reg, flat_reg;
    pt_t        dd_reg, l2_reg;
    logic [7:0] ray_reg;
    pt_t        hv_reg, hh_reg, prev_reg;
    logic [3:0] hcnt_reg, px_reg, py_reg;

    logic       accept, h_ok, is_v, is_h, at_end;
    pt_t        pnext;
    logic [8:0] pidx_full;

    // Clamp the grid sizes and the row indexes.
    always_comb
    begin
        h_eff = (grid_height == 5'd0) ? 5'd1 :
                (grid_height > 5'(MAX_HEIGHT)) ? 5'(MAX_HEIGHT) : grid_height;
        w_eff = (grid_width == 5'd0) ? 5'd1 :
                (grid_width > 5'(MAX_WIDTH)) ? 5'(MAX_WIDTH) : grid_width;
        tx_c  = ({1'b0, s_tdata[3:0]} > h_eff - 5'd1) ? 4'(h_eff - 5'd1) : s_tdata[3:0];
        rx_c  = ({1'b0, s_tdata[7:4]} > h_eff - 5'd1) ? 4'(h_eff - 5'd1) : s_tdata[7:4];
        neg_c  = rx_c < tx_c;
        flat_c = rx_c == tx_c;
        m_c    = flat_c ? 4'd1 : (neg_c ? tx_c - rx_c : rx_c - tx_c);
    end

    // Next crossing: the smaller of the next vertical and horizontal line.
    always_comb
    begin
        h_ok   = !flat_reg && (hcnt_reg < m_reg);
        pnext  = (h_ok && hh_reg < hv_reg) ? hh_reg : hv_reg;
        is_v   = pnext == hv_reg;
        is_h   = h_ok && (pnext == hh_reg);
        at_end = pnext == dd_reg;
        pidx_full = 9'(py_reg * w_reg) + 9'(px_reg);
    end

    assign accept = s_tvalid && s_tready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (accept) state_next = F_RUN;
            F_RUN:   if (push && at_end) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        s_tready = 1'b0;
        push     = 1'b0;
        case (state_reg)
            F_IDLE:  s_tready = 1'b1;
            F_RUN:   push = !full;
            default: s_tready = 1'b0;
        endcase
        push_data.dn   = pnext - prev_reg;
        push_data.dd   = dd_reg;
        push_data.l2   = l2_reg;
        push_data.ray  = ray_reg;
        push_data.px   = px_reg;
        push_data.py   = py_reg;
        push_data.pidx = pidx_full[7:0];
        push_data.last = at_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Ray setup on accept, walk state on every push.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            w_reg    <= w_eff;
            m_reg    <= m_c;
            neg_reg  <= neg_c;
            flat_reg <= flat_c;
            dd_reg   <= 9'({w_eff, 1'b0} * m_c);
            l2_reg   <= 9'(w_eff * w_eff) + 9'(m_c * m_c) - (flat_c ? 9'd1 : 9'd0);
            ray_reg  <= 8'(rx_c * h_eff) + 8'(tx_c);
            hv_reg   <= 9'({m_c, 1'b0});
            hh_reg   <= 9'(w_eff);
            prev_reg <= '0;
            hcnt_reg <= '0;
            px_reg   <= '0;
            py_reg   <= tx_c;
        end
        else if (push)
        begin
            prev_reg <= pnext;
            if (is_v)
            begin
                hv_reg <= hv_reg + 9'({m_reg, 1'b0});
                px_reg <= px_reg + 4'd1;
            end
            if (is_h)
            begin
                hh_reg   <= hh_reg + 9'({w_reg, 1'b0});
                hcnt_reg <= hcnt_reg + 4'd1;
                py_reg   <= neg_reg ? py_reg - 4'd1 : py_reg + 4'd1;
            end
        end
    end

    // A crossing never runs past the receiver end.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_RUN) |-> (prev_reg < dd_reg))
        else $error("crossing walk passed the ray end");

endmodule

[sv/rgil_fifo.sv]
// ----------------------------------------------------------------------------
// rgil_fifo
// Four-entry segment queue between the tracer and the length unit.
// ----------------------------------------------------------------------------
module rgil_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rgil_pkg::seg_t      push_data,
    output logic                full,
    input  logic                pop,
    output rgil_pkg::seg_t      pop_data,
    output logic                empty
);
    import rgil_pkg::*;

    seg_t       mem_reg [4];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] count_reg;

    assign full     = count_reg == 3'd4;
    assign empty    = count_reg == 3'd0;
    assign pop_data = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 2'd1;
            if (pop)
                rptr_reg <= rptr_reg + 2'd1;
            count_reg <= count_reg + (push ? 3'd1 : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("segment queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("segment queue underflow");

endmodule

[sv/rgil_back.sv]
// ----------------------------------------------------------------------------
// rgil_back
// Chord length unit: bit-serial root of dn^2*L2*2^40 divided by D, then
// scaling by grid_size, with a registered result stage.
// ----------------------------------------------------------------------------
module rgil_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         grid_size,
    input  logic                empty,
    output logic                pop,
    input  rgil_pkg::seg_t      pop_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [55:0]         m_tdata,    // ray_index, pixel_x, pixel_y,
                                            // pixel_index, seg_length, zero pad
    output logic                m_tlast
);
    import rgil_pkg::*;

    back_state_t state_reg, state_next;

    seg_t               seg_reg;
    logic [17:0]        dn2_reg, d2_reg;
    logic [26:0]        y_reg;
    logic [ACC_W-1:0]   psq_reg, a_reg, b_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [4:0]         bit_reg;
    logic [24:0]        len_reg;
    logic               out_valid_reg;
    logic [55:0]        out_data_reg;
    logic               out_last_reg;

    logic [ACC_W-1:0]   cand, target;
    logic               take, out_free, load_out;
    logic [36:0]        prod;

    assign target   = {1'b0, y_reg, 40'd0};
    assign cand     = psq_reg + a_reg + b_reg;
    assign take     = cand <= target;
    assign out_free = !out_valid_reg || m_tready;
    assign prod     = 37'(root_reg * grid_size);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (!empty) state_next = B_PREP;
            B_PREP:  state_next = B_PROD;
            B_PROD:  state_next = B_ITER;
            B_ITER:  if (bit_reg == 5'd0) state_next = B_SCALE;
            B_SCALE: state_next = B_OUT;
            B_OUT:   if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            B_IDLE:  pop = !empty;
            B_OUT:   load_out = out_free;
            default: pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath: squares, product, root steps, scaling.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                seg_reg <= pop_data;
            end
            B_PREP:
            begin
                dn2_reg <= seg_reg.dn * seg_reg.dn;
                d2_reg  <= seg_reg.dd * seg_reg.dd;
            end
            B_PROD:
            begin
                y_reg    <= 27'(dn2_reg * seg_reg.l2);
                psq_reg  <= '0;
                a_reg    <= '0;
                b_reg    <= ACC_W'(d2_reg) << (2 * LEN_FRAC);
                root_reg <= '0;
                bit_reg  <= 5'(LEN_FRAC);
            end
            B_ITER:
            begin
                // Try the current root bit against the squared bound.
                if (take)
                begin
                    psq_reg <= cand;
                    a_reg   <= (a_reg + (b_reg << 1)) >> 1;
                end
                else
                begin
                    a_reg <= a_reg >> 1;
                end
                b_reg    <= b_reg >> 2;
                root_reg <= {root_reg[ROOT_BITS-2:0], take};
                bit_reg  <= bit_reg - 5'd1;
            end
            B_SCALE:
            begin
                len_reg <= prod[36:12];
            end
            default:
            begin
                seg_reg <= seg_reg;
            end
        endcase
        if (load_out)
        begin
            out_data_reg <= {7'd0, len_reg, seg_reg.pidx, seg_reg.py,
                             seg_reg.px, seg_reg.ray};
            out_last_reg <= seg_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_ITER) |-> (bit_reg <= 5'(LEN_FRAC)))
        else $error("root step counter out of range");

endmodule
